@@ rtl/mbrtu_pkg.sv @@
`default_nettype none
package mbrtu_pkg;
    localparam int FRAME_MAX = 256;
    localparam int READ_MAX  = 29;
    localparam int CNT_W     = 9;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FN_READ  = 8'h03;
    localparam logic [7:0]  FN_WRITE = 8'h06;
    localparam logic [7:0]  FN_MULTI = 8'h10;
    localparam logic [1:0]  CFG_ADDR = 2'd0;
    localparam logic [1:0]  CFG_X    = 2'd1;
    localparam logic [1:0]  CFG_Y    = 2'd2;
    localparam logic [1:0]  CFG_LANG = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       rx_take;    // absorb one received byte
        logic       frame_clr;  // clear count, CRC and lagged bytes
        logic       do_write;   // apply function 06 write
        logic       tx_init;    // restart the reply CRC and item counter
        logic       tx_adv;     // a reply byte transfer happened
    } mbrtu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       frame_ok;   // CRC, address and length valid
        logic       reply_len_ok;
        logic [6:0] body_len;   // reply bytes before CRC
        logic [6:0] tx_idx;
    } mbrtu_sts_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/mbrtu_datapath.sv @@
`default_nettype none
module mbrtu_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_idx,
    input  wire logic [15:0]       cfg_data,
    input  wire mbrtu_pkg::mbrtu_cmd_t cmd,
    output mbrtu_pkg::mbrtu_sts_t  sts,
    output logic [7:0]             tx_byte
);
    import mbrtu_pkg::*;

    logic [7:0]       hdr_reg [8];
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      crc_reg;
    logic [7:0]       lag0_reg, lag1_reg;
    logic [15:0]      wr_reg [6];
    logic [7:0]       saddr_reg;
    logic [15:0]      x_reg, y_reg, lang_reg;
    logic [15:0]      tcrc_reg;
    logic [6:0]       tidx_reg;

    logic [15:0] start_w, val_w, rx_crc_w, rd_addr, rd_val;
    logic        len_ok;
    logic [2:0]  slot_w;

    assign start_w  = {hdr_reg[2], hdr_reg[3]};
    assign val_w    = {hdr_reg[4], hdr_reg[5]};
    assign rx_crc_w = {lag1_reg, lag0_reg};
    assign len_ok   = (cnt_reg >= CNT_W'(8)) && (cnt_reg <= CNT_W'(FRAME_MAX));

    always_comb begin
        sts.frame_ok = len_ok && (crc_reg == rx_crc_w) && (hdr_reg[0] == saddr_reg);
        sts.reply_len_ok = 1'b0;
        sts.body_len = 7'd6;
        case (hdr_reg[1])
            FN_READ: begin
                sts.reply_len_ok = (cnt_reg == CNT_W'(8)) && (val_w != 16'd0)
                                   && (val_w <= 16'(READ_MAX));
                sts.body_len = 7'd3 + {val_w[5:0], 1'b0};
            end
            FN_WRITE: sts.reply_len_ok = (cnt_reg == CNT_W'(8));
            FN_MULTI: sts.reply_len_ok = (cnt_reg >= CNT_W'(9));
            default:  sts.reply_len_ok = 1'b0;
        endcase
        sts.tx_idx = tidx_reg;
    end

    function automatic logic [2:0] slot_of(input logic [15:0] a);
        case (a)
            16'h0020: slot_of = 3'd0;
            16'h0021: slot_of = 3'd1;
            16'h0022: slot_of = 3'd2;
            16'h0023: slot_of = 3'd3;
            16'h002D: slot_of = 3'd4;
            16'h0030: slot_of = 3'd5;
            default:  slot_of = 3'd7;
        endcase
    endfunction

    // register being read for body byte tidx (bytes 3.. pair per register)
    logic [6:0] roff;
    assign roff    = tidx_reg - 7'd3;
    assign rd_addr = start_w + {10'd0, roff[6:1]};
    assign slot_w  = slot_of(start_w);

    always_comb begin
        case (rd_addr)
            16'h0000: rd_val = x_reg;
            16'h0002: rd_val = y_reg;
            16'h0006: rd_val = lang_reg;
            16'h0010: rd_val = 16'h0020;
            default: begin
                case (slot_of(rd_addr))
                    3'd0: rd_val = wr_reg[0];
                    3'd1: rd_val = wr_reg[1];
                    3'd2: rd_val = wr_reg[2];
                    3'd3: rd_val = wr_reg[3];
                    3'd4: rd_val = wr_reg[4];
                    3'd5: rd_val = wr_reg[5];
                    default: rd_val = 16'h0000;
                endcase
            end
        endcase
    end

    always_comb begin
        if (tidx_reg == sts.body_len) begin
            tx_byte = tcrc_reg[7:0];
        end else if (tidx_reg > sts.body_len) begin
            tx_byte = tcrc_reg[15:8];
        end else if (hdr_reg[1] == FN_READ) begin
            case (tidx_reg)
                7'd0: tx_byte = saddr_reg;
                7'd1: tx_byte = FN_READ;
                7'd2: tx_byte = {val_w[6:0], 1'b0};
                default: tx_byte = roff[0] ? rd_val[7:0] : rd_val[15:8];
            endcase
        end else begin
            tx_byte = hdr_reg[tidx_reg[2:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            crc_reg   <= CRC_INIT;
            lag0_reg  <= '0;
            lag1_reg  <= '0;
            saddr_reg <= 8'h01;
            x_reg     <= '0;
            y_reg     <= '0;
            lang_reg  <= '0;
            tidx_reg  <= '0;
            tcrc_reg  <= CRC_INIT;
            for (int i = 0; i < 6; i++) wr_reg[i] <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_ADDR: saddr_reg <= cfg_data[7:0];
                    CFG_X:    x_reg     <= cfg_data;
                    CFG_Y:    y_reg     <= cfg_data;
                    CFG_LANG: lang_reg  <= cfg_data;
                    default:  ;
                endcase
            end
            if (cmd.rx_take) begin
                if (cnt_reg >= CNT_W'(2)) crc_reg <= crc_byte(crc_reg, lag0_reg);
                lag0_reg <= lag1_reg;
                lag1_reg <= rx_byte;
                if (cnt_reg < CNT_W'(8)) hdr_reg[cnt_reg[2:0]] <= rx_byte;
                if (cnt_reg <= CNT_W'(FRAME_MAX)) cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.frame_clr) begin
                cnt_reg  <= '0;
                crc_reg  <= CRC_INIT;
                lag0_reg <= '0;
                lag1_reg <= '0;
            end
            if (cmd.do_write && (hdr_reg[1] == FN_WRITE) && slot_w != 3'd7)
                wr_reg[slot_w] <= val_w;
            if (cmd.tx_init) begin
                tidx_reg <= '0;
                tcrc_reg <= CRC_INIT;
            end else if (cmd.tx_adv) begin
                tidx_reg <= tidx_reg + 7'd1;
                if (tidx_reg < sts.body_len) tcrc_reg <= crc_byte(tcrc_reg, tx_byte);
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/mbrtu_ctrl.sv @@
`default_nettype none
module mbrtu_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_xfer,
    input  wire logic              frame_end,
    input  wire logic              out_ready,
    input  wire mbrtu_pkg::mbrtu_sts_t sts,
    output mbrtu_pkg::mbrtu_cmd_t  cmd,
    output logic                   in_ready,
    output logic                   out_valid,
    output logic                   out_last
);
    import mbrtu_pkg::*;

    typedef enum logic [1:0] {S_RX, S_CHECK, S_TX} state_t;
    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_RX);
    assign out_valid = (state_reg == S_TX);
    assign out_last  = (sts.tx_idx == sts.body_len + 7'd1);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        cmd.rx_take = in_xfer;
        case (state_reg)
            S_RX: if (in_xfer && frame_end) state_next = S_CHECK;
            S_CHECK: begin
                cmd.frame_clr = 1'b1;
                cmd.tx_init   = 1'b1;
                if (sts.frame_ok && sts.reply_len_ok) begin
                    state_next = S_TX;
                    cmd.do_write = 1'b1;
                end else begin
                    state_next = S_RX;
                end
            end
            S_TX: begin
                cmd.tx_adv = out_ready;
                if (out_ready && out_last) state_next = S_RX;
            end
            default: state_next = S_RX;
        endcase
    end

    // function 06 write is gated by function code in the datapath input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RX;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/modbus_rtu_slave_responder_top.sv @@
`default_nettype none
// Modbus RTU slave: request bytes arrive on s_ with tlast on the final byte;
// the reply streams on m_ with tlast on the final CRC byte. A byte is taken
// every cycle while receiving; after a frame end a check state follows, then
// a valid frame's reply is sent one byte per cycle while m_tready is high
// (function 03 up to 63 bytes); no request byte is taken until its end.
module modbus_rtu_slave_responder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tlast,   // frame_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // tx_byte
    output logic             m_tlast,   // tx_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import mbrtu_pkg::*;

    mbrtu_cmd_t cmd, cmd_g;
    mbrtu_sts_t sts;
    logic in_xfer;

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;

    always_comb begin
        cmd_g = cmd;
    end

    mbrtu_ctrl u_ctrl (
        .aclk, .aresetn, .in_xfer, .frame_end(s_tlast), .out_ready(m_tready),
        .sts, .cmd, .in_ready(s_tready), .out_valid(m_tvalid), .out_last(m_tlast)
    );

    mbrtu_datapath u_dp (
        .aclk, .aresetn, .rx_byte(s_tdata), .cfg_we(cfg_valid),
        .cfg_idx(cfg_index), .cfg_data, .cmd(cmd_g), .sts, .tx_byte(m_tdata)
    );

    a_no_rx_during_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("rx and tx overlap");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid) else $error("tx after last");
    a_write_only_06: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_write |=> m_tvalid) else $error("write without reply");
endmodule
`default_nettype wire
